// ----- rtl/ftb_pkg.sv -----
// ----------------------------------------------------------------------------
// ftb_pkg
// Shared types and constants for the frame to telemetry batcher.
// ----------------------------------------------------------------------------
package ftb_pkg;

   // field widths
   localparam int KIND_W    = 4;
   localparam int CMD_W     = 8;
   localparam int PAYLOAD_W = 64;
   localparam int BYTE_W    = 8;
   localparam int COUNT_W   = 16;
   localparam int SAMPLE_W  = 48;

   // byte staging register: command plus up to eight payload bytes
   localparam int SHREG_W = 72;
   localparam int LEN_W   = 4;

   // bytes per stored bias sample
   localparam int SAMPLE_BYTES = 6;

   // frame kind codes from the upstream decoder
   localparam logic [KIND_W-1:0] KIND_CB_LEVEL    = 4'd0;
   localparam logic [KIND_W-1:0] KIND_SWEEP_LEVEL = 4'd1;
   localparam logic [KIND_W-1:0] KIND_STEPS       = 4'd2;
   localparam logic [KIND_W-1:0] KIND_SWEEP_SET_LO = 4'd3;
   localparam logic [KIND_W-1:0] KIND_SWEEP_SET_HI = 4'd6;
   localparam logic [KIND_W-1:0] KIND_BIAS        = 4'd7;
   localparam logic [KIND_W-1:0] KIND_SENSOR      = 4'd8;
   localparam logic [KIND_W-1:0] KIND_PERIOD      = 4'd9;

   // sample memory strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ftb_ram_ctl_type;

endpackage

// ----- rtl/ftb_if.sv -----
// ----------------------------------------------------------------------------
// ftb_if
// Valid/ready channels of the batcher: frame input, telemetry byte output
// and the mode register write channel.
// ----------------------------------------------------------------------------
interface ftb_req_if;
   logic                            valid;
   logic                            ready;
   logic [ftb_pkg::KIND_W-1:0]      kind;
   logic [ftb_pkg::CMD_W-1:0]       command;
   logic [ftb_pkg::PAYLOAD_W-1:0]   payload;

   modport source (output valid, kind, command, payload, input ready);
   modport sink   (input valid, kind, command, payload, output ready);
endinterface

interface ftb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ftb_pkg::BYTE_W-1:0]  tm_byte;
   logic                        last_byte;
   logic                        needs_service_header;
   logic                        empty_message;

   modport source (output valid, tm_byte, last_byte, needs_service_header,
                   empty_message, input ready);
   modport sink   (input valid, tm_byte, last_byte, needs_service_header,
                   empty_message, output ready);
endinterface

interface ftb_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/frame_to_telemetry_batcher.sv -----
// ----------------------------------------------------------------------------
// frame_to_telemetry_batcher
// Turns decoded instrument frames into telemetry byte runs; batches bias
// samples in a ping-pong sample memory.
// ----------------------------------------------------------------------------
// One frame is taken per transfer on req_bus while the sequencer is idle; its
// message leaves on rsp_bus one byte per transfer, last_byte marking the end.
// A fixed-layout or housekeeping frame is accepted, then its message bytes
// leave one by one. A bias frame that only stores its sample is accepted
// and stored while the sequencer stays idle. A bias frame that flushes a
// batch of n samples sends the header bytes, then for each sample one
// memory read, a wait on the registered read data and six byte transfers.
// The output register lets a new frame in while the final byte waits
// downstream. The mode register on csr_bus must only change while no
// message is in flight. The sample memory needs no clearing pass.
module frame_to_telemetry_batcher #(
   parameter int SAMPLES_PER_BATCH = 10
) (
   input  logic        clock,
   input  logic        reset,
   ftb_req_if.sink     req_bus,
   ftb_rsp_if.source   rsp_bus,
   ftb_csr_if.sink     csr_bus
);

   localparam int ADDR_W = $clog2(SAMPLES_PER_BATCH) + 1;

   logic                              bias_mode_ff;
   ftb_pkg::ftb_ram_ctl_type          ram_ctl;
   logic [ADDR_W-1:0]                 ram_wr_addr;
   logic [ADDR_W-1:0]                 ram_rd_addr;
   logic [ftb_pkg::SAMPLE_W-1:0]      ram_wr_data;
   logic [ftb_pkg::SAMPLE_W-1:0]      ram_rd_data;

   // mode register
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_mode_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         bias_mode_ff <= csr_bus.data;
      end
   end

   ftb_ctrl #(
      .SAMPLES_PER_BATCH (SAMPLES_PER_BATCH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .bias_mode   (bias_mode_ff),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .ram_ctl     (ram_ctl),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   ftb_sample_ram #(
      .ADDR_W (ADDR_W)
   ) u_sample_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ----- rtl/ftb_sample_ram.sv -----
// ----------------------------------------------------------------------------
// ftb_sample_ram
// Ping-pong sample store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ftb_sample_ram #(
   parameter int ADDR_W = 5
) (
   input  logic                            clock,
   input  ftb_pkg::ftb_ram_ctl_type        ctl,
   input  logic [ADDR_W-1:0]               wr_addr,
   input  logic [ftb_pkg::SAMPLE_W-1:0]    wr_data,
   input  logic [ADDR_W-1:0]               rd_addr,
   output logic [ftb_pkg::SAMPLE_W-1:0]    rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [ftb_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic [ftb_pkg::SAMPLE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ftb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ftb_ctrl
// Frame decode, bias batch bookkeeping and the byte sequencer that streams
// messages out of a staging register and the sample memory.
// ----------------------------------------------------------------------------
module ftb_ctrl #(
   parameter int SAMPLES_PER_BATCH = 10
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     bias_mode,
   ftb_req_if.sink                                  req_bus,
   ftb_rsp_if.source                                rsp_bus,
   output ftb_pkg::ftb_ram_ctl_type                 ram_ctl,
   output logic [$clog2(SAMPLES_PER_BATCH):0]       ram_wr_addr,
   output logic [ftb_pkg::SAMPLE_W-1:0]             ram_wr_data,
   output logic [$clog2(SAMPLES_PER_BATCH):0]       ram_rd_addr,
   input  logic [ftb_pkg::SAMPLE_W-1:0]             ram_rd_data
);

   localparam int IDX_W  = $clog2(SAMPLES_PER_BATCH);
   localparam int FILL_W = $clog2(SAMPLES_PER_BATCH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EMIT = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_WAIT = 2'd3;

   // sequencer
   logic [1:0]                       state_ff, state_in;
   logic [ftb_pkg::SHREG_W-1:0]      shreg_ff, shreg_in;
   logic [ftb_pkg::LEN_W-1:0]        len_ff, len_in;
   logic                             hdr_ff, hdr_in;
   logic                             empty_ff, empty_in;
   logic [FILL_W-1:0]                smp_left_ff, smp_left_in;
   logic [IDX_W-1:0]                 smp_idx_ff, smp_idx_in;
   logic                             flush_bank_ff, flush_bank_in;

   // bias batch state
   logic                             bank_ff, bank_in;
   logic [FILL_W-1:0]                fill_ff, fill_in;
   logic [ftb_pkg::COUNT_W-1:0]      expected_ff, expected_in;
   logic                             base_valid_ff, base_valid_in;
   logic [ftb_pkg::COUNT_W-1:0]      start_ff [2];
   logic                             start_we;
   logic                             start_sel;

   // output register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ftb_pkg::BYTE_W-1:0]       rsp_byte_ff, rsp_byte_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic                             rsp_hdr_ff, rsp_hdr_in;
   logic                             rsp_empty_ff, rsp_empty_in;

   logic                             accept;
   logic                             out_free;

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready = (state_ff == ST_IDLE);

   assign rsp_bus.valid                = rsp_valid_ff;
   assign rsp_bus.tm_byte              = rsp_byte_ff;
   assign rsp_bus.last_byte            = rsp_last_ff;
   assign rsp_bus.needs_service_header = rsp_hdr_ff;
   assign rsp_bus.empty_message        = rsp_empty_ff;

   // next-state logic
   always_comb begin
      logic [ftb_pkg::COUNT_W-1:0] cnt;
      logic [ftb_pkg::COUNT_W-1:0] exp_sum;
      logic                        mismatch;
      logic                        new_batch;
      logic                        bank_w;
      logic [FILL_W-1:0]           fill_w;
      logic [FILL_W-1:0]           fill_n;
      logic                        full;

      state_in      = state_ff;
      shreg_in      = shreg_ff;
      len_in        = len_ff;
      hdr_in        = hdr_ff;
      empty_in      = empty_ff;
      smp_left_in   = smp_left_ff;
      smp_idx_in    = smp_idx_ff;
      flush_bank_in = flush_bank_ff;
      bank_in       = bank_ff;
      fill_in       = fill_ff;
      expected_in   = expected_ff;
      base_valid_in = base_valid_ff;
      start_we      = 1'b0;
      start_sel     = bank_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_hdr_in    = rsp_hdr_ff;
      rsp_empty_in  = rsp_empty_ff;

      ram_ctl.wr_en = 1'b0;
      ram_ctl.rd_en = 1'b0;
      ram_rd_addr   = {flush_bank_ff, smp_idx_ff};

      // bias batch decisions for the frame on the input
      cnt       = req_bus.payload[63:48];
      exp_sum   = expected_ff + ftb_pkg::COUNT_W'(fill_ff);
      mismatch  = base_valid_ff && (cnt != exp_sum);
      new_batch = !base_valid_ff || mismatch;
      bank_w    = mismatch ? !bank_ff : bank_ff;
      fill_w    = new_batch ? '0 : fill_ff;
      fill_n    = fill_w + FILL_W'(1);
      full      = (fill_n == FILL_W'(SAMPLES_PER_BATCH));

      ram_wr_addr = {bank_w, fill_w[IDX_W-1:0]};
      ram_wr_data = req_bus.payload[ftb_pkg::SAMPLE_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hdr_in      = 1'b0;
               empty_in    = 1'b0;
               smp_left_in = '0;
               smp_idx_in  = '0;
               state_in    = ST_EMIT;
               case (req_bus.kind) inside
                  ftb_pkg::KIND_CB_LEVEL: begin
                     shreg_in = {req_bus.command, req_bus.payload[63:40], 40'd0};
                     len_in   = 4'd4;
                  end
                  ftb_pkg::KIND_SWEEP_LEVEL: begin
                     shreg_in = {req_bus.command, req_bus.payload[63:32], 32'd0};
                     len_in   = 4'd5;
                  end
                  ftb_pkg::KIND_STEPS: begin
                     shreg_in = {req_bus.command, req_bus.payload[63:56], 56'd0};
                     len_in   = 4'd2;
                  end
                  [ftb_pkg::KIND_SWEEP_SET_LO:ftb_pkg::KIND_SWEEP_SET_HI]: begin
                     shreg_in = {req_bus.command, req_bus.payload[63:48], 48'd0};
                     len_in   = 4'd3;
                  end
                  ftb_pkg::KIND_SENSOR: begin
                     shreg_in = {req_bus.payload, 8'd0};
                     len_in   = 4'd8;
                     hdr_in   = 1'b1;
                  end
                  ftb_pkg::KIND_PERIOD: begin
                     shreg_in = {req_bus.payload[63:48], 56'd0};
                     len_in   = 4'd2;
                     hdr_in   = 1'b1;
                  end
                  ftb_pkg::KIND_BIAS: begin
                     if (!bias_mode) begin
                        state_in = ST_IDLE;
                     end else begin
                        // open a new batch on first sample or broken sequence
                        if (new_batch) begin
                           start_we    = 1'b1;
                           start_sel   = bank_w;
                           expected_in = cnt;
                        end
                        ram_ctl.wr_en = 1'b1;
                        // flush header: command, start count of flushed bank
                        len_in = 4'd3;
                        if (mismatch) begin
                           shreg_in      = {req_bus.command, start_ff[bank_ff], 48'd0};
                           flush_bank_in = bank_ff;
                           smp_left_in   = fill_ff;
                        end else begin
                           shreg_in      = {req_bus.command,
                                            new_batch ? cnt : start_ff[bank_ff], 48'd0};
                           flush_bank_in = bank_w;
                           smp_left_in   = FILL_W'(SAMPLES_PER_BATCH);
                        end
                        if (full) begin
                           fill_in       = '0;
                           base_valid_in = 1'b0;
                           bank_in       = !bank_w;
                        end else begin
                           fill_in       = fill_n;
                           base_valid_in = 1'b1;
                           bank_in       = bank_w;
                        end
                        if (!mismatch && !full) begin
                           state_in = ST_IDLE;
                        end
                     end
                  end
                  default: begin
                     // unknown kind: single empty-message transfer
                     shreg_in = '0;
                     len_in   = 4'd1;
                     empty_in = 1'b1;
                  end
               endcase
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = shreg_ff[ftb_pkg::SHREG_W-1 -: ftb_pkg::BYTE_W];
               rsp_last_in  = (len_ff == 4'd1) && (smp_left_ff == '0);
               rsp_hdr_in   = hdr_ff;
               rsp_empty_in = empty_ff;
               shreg_in     = {shreg_ff[ftb_pkg::SHREG_W-ftb_pkg::BYTE_W-1:0],
                               {ftb_pkg::BYTE_W{1'b0}}};
               len_in       = len_ff - 4'd1;
               if (len_ff == 4'd1) begin
                  state_in = (smp_left_ff != '0) ? ST_READ : ST_IDLE;
               end
            end
         end

         ST_READ: begin
            ram_ctl.rd_en = 1'b1;
            state_in      = ST_WAIT;
         end

         ST_WAIT: begin
            // sample arrives from the memory, queue its six bytes
            shreg_in    = {ram_rd_data, 24'd0};
            len_in      = ftb_pkg::LEN_W'(ftb_pkg::SAMPLE_BYTES);
            smp_idx_in  = smp_idx_ff + IDX_W'(1);
            smp_left_in = smp_left_ff - FILL_W'(1);
            state_in    = ST_EMIT;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bank_ff       <= 1'b0;
         fill_ff       <= '0;
         expected_ff   <= '0;
         base_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bank_ff       <= bank_in;
         fill_ff       <= fill_in;
         expected_ff   <= expected_in;
         base_valid_ff <= base_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      shreg_ff      <= shreg_in;
      len_ff        <= len_in;
      hdr_ff        <= hdr_in;
      empty_ff      <= empty_in;
      smp_left_ff   <= smp_left_in;
      smp_idx_ff    <= smp_idx_in;
      flush_bank_ff <= flush_bank_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_hdr_ff    <= rsp_hdr_in;
      rsp_empty_ff  <= rsp_empty_in;
      if (start_we) begin
         start_ff[start_sel] <= req_bus.payload[63:48];
      end
   end

endmodule

// ----- dv/tb_frame_to_telemetry_batcher.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_to_telemetry_batcher
// Self-checking bench for the frame to telemetry batcher. A queue-fed driver
// sends frames in random bursts. Each accepted frame runs through a local
// model of the message builder and the ping-pong bias batcher. A monitor
// under a random stall pattern, with one long hold-off, compares every
// telemetry byte against the oldest predicted byte.
// ----------------------------------------------------------------------------
module tb_frame_to_telemetry_batcher;

   localparam int BATCH_LEN     = 10;
   localparam int STORE_SLOTS   = 2 * BATCH_LEN;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AT       = 60;
   localparam int RESET_CYCLES  = 12;

   localparam logic MODE_NORMAL = 1'b0;
   localparam logic MODE_BIAS   = 1'b1;

   // receiver stall patterns
   localparam int unsigned STALL_NONE  = 0;
   localparam int unsigned STALL_LIGHT = 1;
   localparam int unsigned STALL_HEAVY = 2;

   localparam logic [ftb_pkg::KIND_W-1:0] KIND_UNKNOWN_LO = ftb_pkg::KIND_PERIOD + 4'd1;
   localparam logic [ftb_pkg::KIND_W-1:0] KIND_UNKNOWN_HI = '1;

   typedef struct packed {
      logic [ftb_pkg::KIND_W-1:0]    kind;
      logic [ftb_pkg::CMD_W-1:0]     command;
      logic [ftb_pkg::PAYLOAD_W-1:0] payload;
   } frame_type;

   typedef struct packed {
      logic [ftb_pkg::BYTE_W-1:0] tm_byte;
      logic                       last_byte;
      logic                       needs_service_header;
      logic                       empty_message;
   } tm_item_type;

   logic clock;
   logic reset;

   ftb_req_if req_bus ();
   ftb_rsp_if rsp_bus ();
   ftb_csr_if csr_bus ();

   frame_to_telemetry_batcher #(
      .SAMPLES_PER_BATCH (BATCH_LEN)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // model state of the batcher
   logic                         bias_mode;
   logic [ftb_pkg::SAMPLE_W-1:0] sample_mem [STORE_SLOTS];
   logic [ftb_pkg::COUNT_W-1:0]  start_count [2];
   logic                         bank;
   int unsigned                  fill;
   logic [ftb_pkg::COUNT_W-1:0]  base_count;
   logic                         base_ok;

   logic [ftb_pkg::BYTE_W-1:0] msg_bytes [$];
   tm_item_type                tm_expect [$];
   frame_type                  frame_pending [$];

   int unsigned n_queued;
   int unsigned n_accepted;
   int unsigned n_results;
   int unsigned error_count;
   int unsigned hold_cnt;
   logic        hold_done;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                  input logic [63:0] want_v);
      $display("MISMATCH result %0d: %s got 0x%0h want 0x%0h",
               n_results, what, got_v, want_v);
      error_count++;
   endtask

   function automatic logic [ftb_pkg::BYTE_W-1:0] frame_byte(
      input logic [ftb_pkg::PAYLOAD_W-1:0] p, input int i);
      return p[ftb_pkg::PAYLOAD_W-1-ftb_pkg::BYTE_W*i -: ftb_pkg::BYTE_W];
   endfunction

   // flush message of the active bank: command, start count, n samples
   task automatic append_batch(input logic [ftb_pkg::CMD_W-1:0] cmd,
                               input int unsigned n);
      logic [ftb_pkg::SAMPLE_W-1:0] s;
      msg_bytes.push_back(cmd);
      msg_bytes.push_back(start_count[bank][ftb_pkg::COUNT_W-1 -: ftb_pkg::BYTE_W]);
      msg_bytes.push_back(start_count[bank][ftb_pkg::BYTE_W-1:0]);
      for (int unsigned k = 0; k < n; k++) begin
         s = sample_mem[int'(bank) * BATCH_LEN + k];
         for (int b = 0; b < ftb_pkg::SAMPLE_BYTES; b++)
            msg_bytes.push_back(s[ftb_pkg::SAMPLE_W-1-ftb_pkg::BYTE_W*b -: ftb_pkg::BYTE_W]);
      end
   endtask

   // expected telemetry bytes for one accepted frame
   task automatic predict_frame(input frame_type f);
      logic                        hdr;
      logic [ftb_pkg::COUNT_W-1:0] cnt;
      logic [ftb_pkg::COUNT_W-1:0] next_count;
      tm_item_type                 t;
      hdr = 1'b0;
      cnt = f.payload[ftb_pkg::PAYLOAD_W-1 -: ftb_pkg::COUNT_W];
      msg_bytes.delete();
      if (f.kind == ftb_pkg::KIND_CB_LEVEL) begin
         msg_bytes.push_back(f.command);
         for (int i = 0; i < 3; i++) msg_bytes.push_back(frame_byte(f.payload, i));
      end else if (f.kind == ftb_pkg::KIND_SWEEP_LEVEL) begin
         msg_bytes.push_back(f.command);
         for (int i = 0; i < 4; i++) msg_bytes.push_back(frame_byte(f.payload, i));
      end else if (f.kind == ftb_pkg::KIND_STEPS) begin
         msg_bytes.push_back(f.command);
         msg_bytes.push_back(frame_byte(f.payload, 0));
      end else if (f.kind >= ftb_pkg::KIND_SWEEP_SET_LO &&
                   f.kind <= ftb_pkg::KIND_SWEEP_SET_HI) begin
         msg_bytes.push_back(f.command);
         for (int i = 0; i < 2; i++) msg_bytes.push_back(frame_byte(f.payload, i));
      end else if (f.kind == ftb_pkg::KIND_SENSOR) begin
         hdr = 1'b1;
         for (int i = 0; i < 8; i++) msg_bytes.push_back(frame_byte(f.payload, i));
      end else if (f.kind == ftb_pkg::KIND_PERIOD) begin
         hdr = 1'b1;
         for (int i = 0; i < 2; i++) msg_bytes.push_back(frame_byte(f.payload, i));
      end else if (f.kind == ftb_pkg::KIND_BIAS) begin
         // bias frames only matter in bias mode
         if (bias_mode) begin
            next_count = base_count + ftb_pkg::COUNT_W'(fill);
            if (!base_ok) begin
               start_count[bank] = cnt;
               base_count = cnt;
               base_ok = 1'b1;
               fill = 0;
            end else if (cnt != next_count) begin
               // count out of sequence: flush and restart in the other bank
               append_batch(f.command, fill);
               bank = ~bank;
               fill = 0;
               start_count[bank] = cnt;
               base_count = cnt;
               base_ok = 1'b1;
            end
            sample_mem[int'(bank) * BATCH_LEN + fill] = f.payload[ftb_pkg::SAMPLE_W-1:0];
            fill++;
            if (fill == BATCH_LEN) begin
               append_batch(f.command, BATCH_LEN);
               fill = 0;
               base_ok = 1'b0;
               bank = ~bank;
            end
         end
      end else begin
         // unknown kind: one empty-message item
         t = '{tm_byte: '0, last_byte: 1'b1, needs_service_header: 1'b0,
               empty_message: 1'b1};
         tm_expect.push_back(t);
      end
      for (int i = 0; i < msg_bytes.size(); i++) begin
         t = '{tm_byte: msg_bytes[i], last_byte: (i == msg_bytes.size() - 1),
               needs_service_header: hdr, empty_message: 1'b0};
         tm_expect.push_back(t);
      end
   endtask

   // frame driver: bursts of random length, random gaps between them
   always @(posedge clock) begin
      logic        offer;
      frame_type   frame_now;
      int unsigned burst_left;
      int unsigned gap_left;
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.kind    <= '0;
         req_bus.command <= '0;
         req_bus.payload <= '0;
         n_accepted      <= 0;
         burst_left = 0;
         gap_left   = 0;
         frame_now  = '0;
         bank       = 1'b0;
         fill       = 0;
         base_count = '0;
         base_ok    = 1'b0;
         start_count[0] = '0;
         start_count[1] = '0;
         for (int i = 0; i < STORE_SLOTS; i++) sample_mem[i] = '0;
      end else begin
         offer = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            predict_frame(frame_now);
            n_accepted <= n_accepted + 1;
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (frame_pending.size() != 0) begin
               frame_now = frame_pending.pop_front();
               offer = 1'b1;
               if (burst_left == 0) burst_left = $urandom_range(1, 12);
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end
         end
         req_bus.valid   <= offer;
         req_bus.kind    <= frame_now.kind;
         req_bus.command <= frame_now.command;
         req_bus.payload <= frame_now.payload;
      end
   end

   // one long receiver hold-off once traffic is flowing
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt  <= 0;
         hold_done <= 1'b0;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
         hold_cnt  <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // telemetry monitor and receiver stall pattern
   always @(posedge clock) begin
      tm_item_type got;
      tm_item_type want;
      logic        rdy;
      int unsigned stretch_left;
      int unsigned stall_mode;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stretch_left = 0;
         stall_mode   = STALL_NONE;
         n_results    = 0;
         error_count  = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{tm_byte: rsp_bus.tm_byte, last_byte: rsp_bus.last_byte,
                    needs_service_header: rsp_bus.needs_service_header,
                    empty_message: rsp_bus.empty_message};
            if (tm_expect.size() == 0) begin
               report_mismatch("unexpected transfer", 64'(got), 64'(0));
            end else begin
               want = tm_expect.pop_front();
               if (got.tm_byte !== want.tm_byte)
                  report_mismatch("tm_byte", 64'(got.tm_byte), 64'(want.tm_byte));
               if (got.last_byte !== want.last_byte)
                  report_mismatch("last_byte", 64'(got.last_byte),
                                  64'(want.last_byte));
               if (got.needs_service_header !== want.needs_service_header)
                  report_mismatch("needs_service_header",
                                  64'(got.needs_service_header),
                                  64'(want.needs_service_header));
               if (got.empty_message !== want.empty_message)
                  report_mismatch("empty_message", 64'(got.empty_message),
                                  64'(want.empty_message));
            end
            n_results++;
         end
         // stretches of always-ready, light stalls and heavy stalls
         if (stretch_left == 0) begin
            stall_mode   = $urandom_range(STALL_NONE, STALL_HEAVY);
            stretch_left = $urandom_range(8, 60);
         end
         stretch_left--;
         case (stall_mode)
            STALL_NONE:  rdy = 1'b1;
            STALL_LIGHT: rdy = 1'($urandom_range(0, 1));
            default:     rdy = ($urandom_range(0, 3) == 0);
         endcase
         rsp_bus.ready <= rdy && (hold_cnt == 0);
      end
   end

   task automatic push_frame(input logic [ftb_pkg::KIND_W-1:0] kind,
                             input logic [ftb_pkg::CMD_W-1:0] cmd,
                             input logic [ftb_pkg::PAYLOAD_W-1:0] payload);
      frame_type f;
      f = '{kind: kind, command: cmd, payload: payload};
      frame_pending.push_back(f);
      n_queued++;
   endtask

   function automatic logic [ftb_pkg::PAYLOAD_W-1:0] rand_payload();
      return {$urandom, $urandom};
   endfunction

   // waits until every frame is in and every byte out, then lets the block settle
   task automatic wait_drained();
      do @(negedge clock);
      while (n_accepted != n_queued || tm_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input logic m);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= m;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      bias_mode = m;
   endtask

   // bias mode traffic: mostly counted runs, some broken counts and other kinds
   task automatic gen_bias_phase(input int unsigned n);
      int unsigned                  done;
      int unsigned                  run_len;
      logic [ftb_pkg::COUNT_W-1:0]  cnt;
      logic [ftb_pkg::KIND_W-1:0]   k;
      logic [ftb_pkg::SAMPLE_W-1:0] s;
      done = 0;
      @(negedge clock);
      while (done < n) begin
         if ($urandom_range(0, 9) < 7) begin
            run_len = $urandom_range(1, 12);
            cnt = ($urandom_range(0, 3) == 0)
                  ? ftb_pkg::COUNT_W'(16'hFFFF - $urandom_range(0, 5))
                  : ftb_pkg::COUNT_W'($urandom);
            for (int unsigned j = 0; j < run_len; j++) begin
               s = {16'($urandom), $urandom};
               if ($urandom_range(0, 7) == 0) cnt = ftb_pkg::COUNT_W'($urandom);
               push_frame(ftb_pkg::KIND_BIAS, ftb_pkg::CMD_W'($urandom), {cnt, s});
               cnt++;
               done++;
            end
         end else begin
            k = ftb_pkg::KIND_W'($urandom_range(0, 14));
            if (k >= ftb_pkg::KIND_BIAS) k++;
            push_frame(k, ftb_pkg::CMD_W'($urandom), rand_payload());
            done++;
         end
      end
   endtask

   // normal mode traffic over every kind; ignored bias frames do not count
   task automatic gen_mixed_phase(input int unsigned n);
      int unsigned                done;
      logic [ftb_pkg::KIND_W-1:0] k;
      done = 0;
      @(negedge clock);
      while (done < n) begin
         k = ftb_pkg::KIND_W'($urandom);
         push_frame(k, ftb_pkg::CMD_W'($urandom), rand_payload());
         if (k != ftb_pkg::KIND_BIAS) done++;
      end
   endtask

   // main sequence
   initial begin
      reset         = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.data  = 1'b0;
      bias_mode     = MODE_NORMAL;
      n_queued      = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed, normal mode: every kind, field extremes, ignored bias frame
      @(negedge clock);
      push_frame(ftb_pkg::KIND_CB_LEVEL, 8'h00, 64'h0);
      push_frame(ftb_pkg::KIND_SWEEP_LEVEL, 8'hFF, '1);
      push_frame(ftb_pkg::KIND_STEPS, 8'hA5, 64'h0123_4567_89AB_CDEF);
      for (int k = ftb_pkg::KIND_SWEEP_SET_LO; k <= ftb_pkg::KIND_SWEEP_SET_HI; k++)
         push_frame(ftb_pkg::KIND_W'(k), ftb_pkg::CMD_W'($urandom), rand_payload());
      push_frame(ftb_pkg::KIND_SENSOR, 8'h5A, '1);
      push_frame(ftb_pkg::KIND_PERIOD, 8'h00, 64'h8000_0000_0000_0001);
      push_frame(KIND_UNKNOWN_LO, 8'hFF, '1);
      push_frame(KIND_UNKNOWN_HI, 8'h00, 64'h0);
      push_frame(ftb_pkg::KIND_BIAS, 8'h11, rand_payload());
      wait_drained();

      // directed, bias mode: full batch across the count wrap, then breaks
      write_mode(MODE_BIAS);
      @(negedge clock);
      for (int j = 0; j < BATCH_LEN; j++)
         push_frame(ftb_pkg::KIND_BIAS, (j % 2) ? 8'hFF : 8'h00,
                    {ftb_pkg::COUNT_W'(16'hFFFB + j),
                     (j % 2) ? 48'hFFFF_FFFF_FFFF : 48'h0});
      push_frame(ftb_pkg::KIND_BIAS, 8'h21, {16'd5, 48'h1111_2222_3333});
      push_frame(ftb_pkg::KIND_BIAS, 8'h22, {16'd6, 48'h4444_5555_6666});
      push_frame(ftb_pkg::KIND_BIAS, 8'h23, {16'd100, 48'h7777_8888_9999});
      push_frame(ftb_pkg::KIND_BIAS, 8'h24, {16'd200, 48'hAAAA_BBBB_CCCC});
      wait_drained();

      // random phases over both mode settings
      gen_bias_phase(70);
      wait_drained();
      write_mode(MODE_NORMAL);
      gen_mixed_phase(40);
      wait_drained();
      write_mode(MODE_BIAS);
      gen_bias_phase(80);
      wait_drained();

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/ftb_pkg.sv
rtl/ftb_if.sv
rtl/ftb_sample_ram.sv
rtl/ftb_ctrl.sv
rtl/frame_to_telemetry_batcher.sv
dv/tb_frame_to_telemetry_batcher.sv
